// ----- rtl/ecd_pkg.sv -----
package ecd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } ecd_state_t;

    localparam logic [4:0]  STEP_DAY_MUL    = 5'd1;
    localparam logic [4:0]  STEP_DAY_SPLIT  = 5'd0;
    localparam logic [4:0]  STEP_HOUR       = 5'd0;
    localparam logic [4:0]  STEP_MSEC       = 5'd1;
    localparam logic [4:0]  STEP_MIN        = 5'd2;
    localparam logic [4:0]  STEP_SEC        = 5'd3;
    localparam logic [4:0]  DIV_TOP         = STEP_DAY_MUL;
    localparam logic [4:0]  SPLIT_END       = 5'd4;

    // floor(x / d) as (x * RECIP) >> shift, exact over each operand range
    localparam logic [26:0] DAY_RECIP       = 27'd101806633;
    localparam logic [13:0] HOUR_RECIP      = 14'd9321;
    localparam logic [10:0] MIN_RECIP       = 11'd1093;
    localparam logic [17:0] WEEK_RECIP      = 18'd149797;

    localparam logic [16:0] SECS_PER_DAY_LO  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR_LO = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN_LO  = 6'd60;
    localparam logic [33:0] SECS_PER_HOUR_W = 34'd3600;
    localparam logic [11:0] BASE_YEAR       = 12'd1970;
    localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;
    localparam logic [8:0]  DAYS_LEAP       = 9'd366;
    localparam logic [8:0]  DAYS_COMMON     = 9'd365;
    localparam logic [16:0] EPOCH_WEEKDAY   = 17'd4;
    localparam logic [2:0]  WEEK_LEN        = 3'd7;
    localparam logic [3:0]  MONTH_JAN       = 4'd1;
    localparam logic [3:0]  MONTH_FEB       = 4'd2;
    localparam logic [3:0]  MONTH_APR       = 4'd4;
    localparam logic [3:0]  MONTH_JUN       = 4'd6;
    localparam logic [3:0]  MONTH_SEP       = 4'd9;
    localparam logic [3:0]  MONTH_NOV       = 4'd11;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       split_step;
        logic       year_step;
        logic       month_step;
        logic [4:0] cnt;
    } ecd_cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } ecd_status_t;

    // leap rule over the reachable years 1970 to 2106
    function automatic logic is_leap_year(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/ecd_dp.sv -----
module ecd_dp (
    input  logic                clk,
    input  ecd_pkg::ecd_cmd_t   cmd,
    input  logic [31:0]         epoch_seconds,
    input  logic signed [4:0]   utc_offset_hours,
    output ecd_pkg::ecd_status_t status,
    output logic [11:0]         calendar_year,
    output logic [3:0]          calendar_month,
    output logic [4:0]          day_of_month,
    output logic [4:0]          hour_of_day,
    output logic [5:0]          minute_of_hour,
    output logic [5:0]          second_of_minute,
    output logic [2:0]          weekday,
    output logic                clamped
);

    logic [32:0] rem_reg;
    logic [16:0] days_reg;
    logic [16:0] sod_reg;
    logic [16:0] wsum_reg;
    logic [2:0]  week_q_reg;
    logic [11:0] msec_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  wday_reg;
    logic [16:0] yrem_reg;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic        clamped_reg;

    logic signed [33:0] off_wide;
    logic signed [33:0] off_prod;
    logic signed [33:0] local_sum;
    logic [52:0] day_prod_next;
    logic [16:0] sod_next;
    logic [16:0] wsum_next;
    logic [34:0] week_prod_next;
    logic [26:0] hour_prod_next;
    logic [11:0] msec_next;
    logic [2:0]  wday_next;
    logic [20:0] min_prod_next;
    logic [5:0]  second_next;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;

    always_comb
    begin
        off_wide  = {{29{utc_offset_hours[4]}}, utc_offset_hours};
        off_prod  = off_wide * $signed(ecd_pkg::SECS_PER_HOUR_W);
        local_sum = $signed({2'b00, epoch_seconds}) + off_prod;

        day_prod_next  = {27'd0, rem_reg[32:7]} * {26'd0, ecd_pkg::DAY_RECIP};
        sod_next       = rem_reg[16:0] - days_reg * ecd_pkg::SECS_PER_DAY_LO;
        wsum_next      = days_reg + ecd_pkg::EPOCH_WEEKDAY;

        week_prod_next = {18'd0, wsum_reg} * {17'd0, ecd_pkg::WEEK_RECIP};
        hour_prod_next = {14'd0, sod_reg[16:4]} * {13'd0, ecd_pkg::HOUR_RECIP};
        msec_next      = sod_reg[11:0] - {7'd0, hour_reg} * ecd_pkg::SECS_PER_HOUR_LO;
        wday_next      = wsum_reg[2:0] - week_q_reg * ecd_pkg::WEEK_LEN;
        min_prod_next  = {11'd0, msec_reg[11:2]} * {10'd0, ecd_pkg::MIN_RECIP};
        second_next    = msec_reg[5:0] - minute_reg * ecd_pkg::SECS_PER_MIN_LO;

        leap     = ecd_pkg::is_leap_year(year_reg);
        year_len = leap ? ecd_pkg::DAYS_LEAP : ecd_pkg::DAYS_COMMON;
        mon_len  = ecd_pkg::month_days(month_reg, leap);

        status.year_fit  = yrem_reg < {8'd0, year_len};
        status.month_fit = yrem_reg < {12'd0, mon_len};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clamped_reg <= local_sum[33];
            rem_reg     <= local_sum[33] ? 33'd0 : local_sum[32:0];
        end
        if (cmd.div_step)
        begin
            if (cmd.cnt == ecd_pkg::STEP_DAY_MUL)
            begin
                days_reg <= day_prod_next[52:36];
            end
            else if (cmd.cnt == ecd_pkg::STEP_DAY_SPLIT)
            begin
                sod_reg   <= sod_next;
                wsum_reg  <= wsum_next;
                yrem_reg  <= days_reg;
                year_reg  <= ecd_pkg::BASE_YEAR;
                month_reg <= ecd_pkg::MONTH_JAN;
            end
        end
        if (cmd.split_step)
        begin
            unique case (cmd.cnt)
                ecd_pkg::STEP_HOUR:
                begin
                    hour_reg   <= hour_prod_next[25:21];
                    week_q_reg <= week_prod_next[22:20];
                end
                ecd_pkg::STEP_MSEC:
                begin
                    msec_reg <= msec_next;
                    wday_reg <= wday_next;
                end
                ecd_pkg::STEP_MIN:
                begin
                    minute_reg <= min_prod_next[19:14];
                end
                ecd_pkg::STEP_SEC:
                begin
                    second_reg <= second_next;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.year_step && !status.year_fit)
        begin
            yrem_reg <= yrem_reg - {8'd0, year_len};
            year_reg <= year_reg + 12'd1;
        end
        if (cmd.month_step && !status.month_fit)
        begin
            yrem_reg  <= yrem_reg - {12'd0, mon_len};
            month_reg <= month_reg + 4'd1;
        end
    end

    assign calendar_year    = year_reg;
    assign calendar_month   = month_reg;
    assign day_of_month     = yrem_reg[4:0] + 5'd1;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = minute_reg;
    assign second_of_minute = second_reg;
    assign weekday          = wday_reg;
    assign clamped          = clamped_reg;

endmodule

// ----- rtl/ecd_ctrl.sv -----
module ecd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  ecd_pkg::ecd_status_t status,
    output ecd_pkg::ecd_cmd_t    cmd
);

    ecd_pkg::ecd_state_t state_reg;
    ecd_pkg::ecd_state_t state_next;
    logic [4:0]          cnt_reg;
    logic [4:0]          cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecd_pkg::ST_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.cnt        = cnt_reg;
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        unique case (state_reg)
            ecd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = ecd_pkg::DIV_TOP;
                    state_next = ecd_pkg::ST_DIV;
                end
            end
            ecd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = ecd_pkg::ST_YEAR;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ecd_pkg::ST_YEAR:
            begin
                cmd.year_step  = 1'b1;
                cmd.split_step = cnt_reg != ecd_pkg::SPLIT_END;
                if (cmd.split_step)
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
                else if (status.year_fit)
                begin
                    state_next = ecd_pkg::ST_MONTH;
                end
            end
            ecd_pkg::ST_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (status.month_fit)
                begin
                    state_next = ecd_pkg::ST_DONE;
                end
            end
            ecd_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ecd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecd_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.year_step, cmd.month_step}))
        else $error("more than one datapath command");

    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ecd_pkg::ST_DIV && cnt_reg == ecd_pkg::DIV_TOP))
        else $error("accepted item did not start the day division");

    a_div_to_year: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ecd_pkg::ST_DIV && cnt_reg == 5'd0) |=>
        (state_reg == ecd_pkg::ST_YEAR && cnt_reg == 5'd0))
        else $error("division did not hand over to the year walk");

    a_year_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ecd_pkg::ST_YEAR && state_next == ecd_pkg::ST_MONTH) |->
        (cnt_reg == ecd_pkg::SPLIT_END && status.year_fit))
        else $error("month walk began before year walk and time split finished");
`endif

endmodule

// ----- rtl/epoch_seconds_to_calendar_date.sv -----
// An accepted item goes through the day division, then the year walk, which steps one
// year per cycle with the time split beside it, then the month walk. Throughput: one
// item at a time; the next item can be taken in the cycle after the result leaves.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and drops any
// item in flight; datapath registers are not reset.
module epoch_seconds_to_calendar_date (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       epoch_seconds,
    input  logic signed [4:0] utc_offset_hours,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [11:0]       calendar_year,
    output logic [3:0]        calendar_month,
    output logic [4:0]        day_of_month,
    output logic [4:0]        hour_of_day,
    output logic [5:0]        minute_of_hour,
    output logic [5:0]        second_of_minute,
    output logic [2:0]        weekday,
    output logic              clamped
);

    ecd_pkg::ecd_cmd_t    cmd;
    ecd_pkg::ecd_status_t status;

    ecd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ecd_dp u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .epoch_seconds    (epoch_seconds),
        .utc_offset_hours (utc_offset_hours),
        .status           (status),
        .calendar_year    (calendar_year),
        .calendar_month   (calendar_month),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .weekday          (weekday),
        .clamped          (clamped)
    );

endmodule
